// ----- hw/rtl/nsc_pkg.sv -----
// Shared types and constants for the NMEA sentence checker and classifier.
// No dependencies; used by nsc_line_state and nmea_sentence_check_classify.
package nsc_pkg;

    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam logic [3:0] KIND_INVALID = 4'd0;
    localparam logic [3:0] KIND_UNKNOWN = 4'd1;
    localparam logic [3:0] KIND_RMC     = 4'd2;
    localparam logic [3:0] KIND_GGA     = 4'd3;
    localparam logic [3:0] KIND_GSA     = 4'd4;
    localparam logic [3:0] KIND_GLL     = 4'd5;
    localparam logic [3:0] KIND_GST     = 4'd6;
    localparam logic [3:0] KIND_GSV     = 4'd7;
    localparam logic [3:0] KIND_VTG     = 4'd8;

    localparam logic [6:0] LEN_SAT = 7'd127;

    typedef struct packed {
        logic [3:0]  sentence_kind;
        logic [15:0] talker_code;
        logic [7:0]  computed_checksum;
        logic        had_checksum;
    } nsc_result_t;

endpackage

// ----- hw/rtl/nsc_line_state.sv -----
// Per-line tracking state: length, body XOR, checksum digits and ident bytes.
// Produces the line result from the current state. Depends on nsc_pkg.
module nsc_line_state import nsc_pkg::*; #(
    parameter int MAX_LENGTH = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        strict_mode,
    input  logic        byte_fire,
    input  logic [7:0]  data_byte,
    output nsc_result_t result
);

    typedef enum logic [2:0] {
        PH_DOLLAR,
        PH_BODY,
        PH_HI,
        PH_LO,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        V_PENDING,
        V_PASS,
        V_FAIL
    } verdict_t;

    localparam logic [6:0] LEN_LIMIT = 7'(MAX_LENGTH + 3);

    phase_t      phase_reg, phase_next;
    verdict_t    verdict_reg, verdict_next;
    logic [6:0]  len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    logic [3:0]  hi_reg, hi_next;
    logic [39:0] ident_reg, ident_next;
    logic        ident_ok_reg, ident_ok_next;
    logic        seen_reg, seen_next;

    logic        printable;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        is_lf;
    logic        line_pass;
    logic [23:0] type_code;
    logic [3:0]  kind;

    always_comb begin
        printable = (data_byte >= 8'h20) && (data_byte <= 8'h7E);
        hex_ok    = 1'b1;
        hex_val   = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
            hex_val = data_byte[3:0];
        end else if ((data_byte >= 8'h41 && data_byte <= 8'h46)
                     || (data_byte >= 8'h61 && data_byte <= 8'h66)) begin
            hex_val = data_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign is_lf = (data_byte == CHAR_LF);

    always_comb begin
        phase_next    = phase_reg;
        verdict_next  = verdict_reg;
        len_next      = len_reg;
        xor_next      = xor_reg;
        hi_next       = hi_reg;
        ident_next    = ident_reg;
        ident_ok_next = ident_ok_reg;
        seen_next     = seen_reg;

        if (byte_fire && is_lf) begin
            phase_next    = PH_DOLLAR;
            verdict_next  = V_PENDING;
            len_next      = 7'd0;
            xor_next      = 8'd0;
            hi_next       = 4'd0;
            ident_next    = 40'd0;
            ident_ok_next = 1'b1;
            seen_next     = 1'b0;
        end else if (byte_fire) begin
            for (int i = 0; i < 5; i++) begin
                if (len_reg == 7'(i + 1)) begin
                    ident_next[i*8 +: 8] = data_byte;
                    if (!printable || data_byte == CHAR_COMMA || data_byte == CHAR_STAR) begin
                        ident_ok_next = 1'b0;
                    end
                end
            end
            if (len_reg != LEN_SAT) begin
                len_next = len_reg + 7'd1;
            end

            unique case (phase_reg)
                PH_DOLLAR: begin
                    if (data_byte == CHAR_DOLLAR) begin
                        phase_next = PH_BODY;
                    end else begin
                        verdict_next = V_FAIL;
                        phase_next   = PH_DONE;
                    end
                end
                PH_BODY: begin
                    if (data_byte == CHAR_STAR) begin
                        seen_next  = 1'b1;
                        phase_next = PH_HI;
                    end else if (printable) begin
                        xor_next = xor_reg ^ data_byte;
                    end else begin
                        verdict_next = (data_byte == CHAR_CR && !strict_mode) ? V_PASS : V_FAIL;
                        phase_next   = PH_DONE;
                    end
                end
                PH_HI: begin
                    if (hex_ok) begin
                        hi_next    = hex_val;
                        phase_next = PH_LO;
                    end else begin
                        verdict_next = V_FAIL;
                        phase_next   = PH_DONE;
                    end
                end
                PH_LO: begin
                    verdict_next = (hex_ok && {hi_reg, hex_val} == xor_reg) ? V_PASS : V_FAIL;
                    phase_next   = PH_DONE;
                end
                PH_DONE: begin
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_DOLLAR;
            verdict_reg  <= V_PENDING;
            len_reg      <= 7'd0;
            xor_reg      <= 8'd0;
            hi_reg       <= 4'd0;
            ident_reg    <= 40'd0;
            ident_ok_reg <= 1'b1;
            seen_reg     <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            verdict_reg  <= verdict_next;
            len_reg      <= len_next;
            xor_reg      <= xor_next;
            hi_reg       <= hi_next;
            ident_reg    <= ident_next;
            ident_ok_reg <= ident_ok_next;
            seen_reg     <= seen_next;
        end
    end

    assign line_pass = (verdict_reg == V_PASS) && (len_reg <= LEN_LIMIT)
                       && ident_ok_reg && (len_reg >= 7'd6);
    assign type_code = {ident_reg[23:16], ident_reg[31:24], ident_reg[39:32]};

    always_comb begin
        case (type_code)
            {8'h52, 8'h4D, 8'h43}: kind = KIND_RMC;
            {8'h47, 8'h47, 8'h41}: kind = KIND_GGA;
            {8'h47, 8'h53, 8'h41}: kind = KIND_GSA;
            {8'h47, 8'h4C, 8'h4C}: kind = KIND_GLL;
            {8'h47, 8'h53, 8'h54}: kind = KIND_GST;
            {8'h47, 8'h53, 8'h56}: kind = KIND_GSV;
            {8'h56, 8'h54, 8'h47}: kind = KIND_VTG;
            default:               kind = KIND_UNKNOWN;
        endcase
    end

    always_comb begin
        result.sentence_kind     = line_pass ? kind : KIND_INVALID;
        result.talker_code       = line_pass ? {ident_reg[7:0], ident_reg[15:8]} : 16'd0;
        result.computed_checksum = xor_reg;
        result.had_checksum      = seen_reg;
    end

endmodule

// ----- hw/rtl/nmea_sentence_check_classify.sv -----
// Top level of the NMEA sentence checker and classifier.
// A line feed word is captured in the input register, and its result is then
// registered in the output register, which drives the outputs.
// Throughput: one byte word per cycle; a line feed waits only while the
// result register is still held by the downstream side.
// Reset is synchronous and active low; it clears the line state, both
// valid flags and strict_mode. Depends on nsc_pkg and nsc_line_state.
module nmea_sentence_check_classify import nsc_pkg::*; #(
    parameter int MAX_LENGTH = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_sentence_kind,
    output logic [15:0] m_talker_code,
    output logic [7:0]  m_computed_checksum,
    output logic        m_had_checksum
);

    logic        strict_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    nsc_result_t out_reg;
    nsc_result_t line_result;
    logic        in_lf;
    logic        fire;

    assign in_lf   = (in_byte_reg == CHAR_LF);
    assign fire    = in_valid_reg && (!in_lf || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    nsc_line_state #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .strict_mode (strict_reg),
        .byte_fire   (fire),
        .data_byte   (in_byte_reg),
        .result      (line_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                strict_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire && in_lf) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
        if (fire && in_lf) begin
            out_reg <= line_result;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_sentence_kind     = out_reg.sentence_kind;
    assign m_talker_code       = out_reg.talker_code;
    assign m_computed_checksum = out_reg.computed_checksum;
    assign m_had_checksum      = out_reg.had_checksum;

endmodule
